[sv/fccm_pkg.sv]
`default_nettype none

package fccm_pkg;

	localparam logic [31:0] FREE_MARK = 32'h0000_0000;
	localparam logic [31:0] END_MARK  = 32'hFFFF_FFFF;
	localparam logic [31:0] BAD_MARK  = 32'hFFFF_FFFE;

	localparam logic [2:0] CMD_LOAD       = 3'd0;
	localparam logic [2:0] CMD_READ       = 3'd1;
	localparam logic [2:0] CMD_ALLOC      = 3'd2;
	localparam logic [2:0] CMD_APPEND     = 3'd3;
	localparam logic [2:0] CMD_FREE_CHAIN = 3'd4;
	localparam logic [2:0] CMD_NEXT       = 3'd5;
	localparam logic [2:0] CMD_FREE_ONE   = 3'd6;
	localparam logic [2:0] CMD_UNUSED     = 3'd7;

	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_NOFREE = 3'd1;
	localparam logic [2:0] STAT_MARK   = 3'd2;
	localparam logic [2:0] STAT_RANGE  = 3'd3;
	localparam logic [2:0] STAT_LIMIT  = 3'd4;

	localparam logic [10:0] USED_RESET = 11'd1024;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_RDWAIT,
		S_WALK,
		S_SCAN,
		S_LINKWR,
		S_LINK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_CLUS,
		RD_LINK,
		RD_TWO,
		RD_SCAN_NXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_LOAD,
		WR_FREE_CLUS,
		WR_FREE_CUR,
		WR_END_SCAN,
		WR_LINK_TAIL
	} wr_sel_t;

	typedef enum logic {
		RES_SCAN,
		RES_LINK
	} res_sel_t;

	typedef struct packed {
		logic       capture;
		logic       clr_step;
		logic       rd_en;
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		logic       walk_init;
		logic       walk_adv;
		logic       scan_init;
		logic       scan_adv;
		logic       status_we;
		logic [2:0] status_val;
		logic       res_we;
		res_sel_t   res_sel;
		logic       rd_we;
	} dp_ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       in_range;
		logic       clus_low;
		logic       is_free;
		logic       is_end;
		logic       is_bad;
		logic       link_oor;
		logic       steps_at_lim;
		logic       scan_at_end;
		logic       two_at_end;
		logic       clear_last;
	} dp_stat_t;

endpackage

`default_nettype wire

[sv/fccm_dpath.sv]
`default_nettype none

module fccm_dpath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fccm_pkg::dp_ctrl_t ctrl,
	output fccm_pkg::dp_stat_t      stat,
	input  wire logic [2:0]        command,
	input  wire logic [9:0]        cluster,
	input  wire logic [31:0]       entry_value,
	input  wire logic              cfg_valid,
	input  wire logic [10:0]       cfg_data,
	output logic [2:0]             status,
	output logic [9:0]             result_cluster,
	output logic [31:0]            read_value
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMPW = (AW + 1 > 12) ? AW + 1 : 12;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
	localparam logic [11:0] DEPTH_SAT = (TABLE_DEPTH > 2047) ? 12'd2047 : 12'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	logic [31:0]   mem_q [TABLE_DEPTH];
	logic [31:0]   rdata_q;
	logic [2:0]    cmd_q;
	logic [9:0]    clus_q;
	logic [31:0]   val_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] scan_q;
	logic [10:0]   steps_q;
	logic [10:0]   used_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    status_q;
	logic [9:0]    res_q;
	logic [31:0]   rdval_q;

	logic [10:0]   lim;
	logic [AW-1:0] clus_addr;
	logic [AW-1:0] link_addr;
	logic [AW-1:0] scan_nxt;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          wr_en;

	// walk and scan bound: used_clusters clamped to the table depth
	assign lim = ({1'b0, used_q} < DEPTH_SAT) ? used_q : DEPTH_SAT[10:0];

	assign clus_addr = AW'(clus_q);
	assign link_addr = AW'(rdata_q);
	assign scan_nxt  = scan_q + AW'(1);

	always_comb begin
		case (ctrl.rd_sel)
			fccm_pkg::RD_CLUS:     rd_addr = clus_addr;
			fccm_pkg::RD_LINK:     rd_addr = link_addr;
			fccm_pkg::RD_TWO:      rd_addr = AW'(2);
			fccm_pkg::RD_SCAN_NXT: rd_addr = scan_nxt;
			default:               rd_addr = clus_addr;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = cur_q;
		wr_data = fccm_pkg::FREE_MARK;
		case (ctrl.wr_sel)
			fccm_pkg::WR_NONE:      wr_en = 1'b0;
			fccm_pkg::WR_CLEAR:     wr_addr = clr_q;
			fccm_pkg::WR_LOAD: begin
				wr_addr = clus_addr;
				wr_data = val_q;
			end
			fccm_pkg::WR_FREE_CLUS: wr_addr = clus_addr;
			fccm_pkg::WR_FREE_CUR:  wr_addr = cur_q;
			fccm_pkg::WR_END_SCAN: begin
				wr_addr = scan_q;
				wr_data = fccm_pkg::END_MARK;
			end
			fccm_pkg::WR_LINK_TAIL: begin
				wr_addr = cur_q;
				wr_data = 32'(scan_q);
			end
			default:                wr_en = 1'b0;
		endcase
	end

	// table: one write and one read port, write-first on an address clash
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (ctrl.rd_en) begin
			if (wr_en && (wr_addr == rd_addr))
				rdata_q <= wr_data;
			else
				rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= fccm_pkg::USED_RESET;
			clr_q  <= '0;
		end else begin
			if (cfg_valid)
				used_q <= cfg_data;
			if (ctrl.clr_step)
				clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q    <= command;
			clus_q   <= cluster;
			val_q    <= entry_value;
			status_q <= fccm_pkg::STAT_OK;
			res_q    <= '0;
			rdval_q  <= '0;
		end
		if (ctrl.walk_init) begin
			cur_q   <= clus_addr;
			steps_q <= '0;
		end else if (ctrl.walk_adv) begin
			cur_q   <= link_addr;
			steps_q <= steps_q + 11'd1;
		end
		if (ctrl.scan_init)
			scan_q <= AW'(2);
		else if (ctrl.scan_adv)
			scan_q <= scan_nxt;
		if (ctrl.status_we)
			status_q <= ctrl.status_val;
		if (ctrl.res_we)
			res_q <= (ctrl.res_sel == fccm_pkg::RES_SCAN) ? 10'(scan_q) : rdata_q[9:0];
		if (ctrl.rd_we)
			rdval_q <= rdata_q;
	end

	assign stat.cmd          = cmd_q;
	assign stat.in_range     = 32'(clus_q) < DEPTH32;
	assign stat.clus_low     = (clus_q[9:1] == 9'd0);
	assign stat.is_free      = (rdata_q == fccm_pkg::FREE_MARK);
	assign stat.is_end       = (rdata_q == fccm_pkg::END_MARK);
	assign stat.is_bad       = (rdata_q == fccm_pkg::BAD_MARK);
	assign stat.link_oor     = (rdata_q >= DEPTH32);
	assign stat.steps_at_lim = (steps_q >= lim);
	assign stat.scan_at_end  = (CMPW'({1'b0, scan_q} + 1'b1) >= CMPW'(lim));
	assign stat.two_at_end   = (lim <= 11'd2);
	assign stat.clear_last   = (clr_q == LAST_ADDR);

	assign status         = status_q;
	assign result_cluster = res_q;
	assign read_value     = rdval_q;

endmodule

`default_nettype wire

[sv/fccm_ctrl.sv]
`default_nettype none

module fccm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire fccm_pkg::dp_stat_t stat,
	output fccm_pkg::dp_ctrl_t      ctrl,
	output logic                    busy,
	output logic                    done
);

	fccm_pkg::state_t state_q;
	fccm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fccm_pkg::S_CLEAR;
		else
			state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fccm_pkg::S_CLEAR:
				if (stat.clear_last)
					state_nxt = fccm_pkg::S_IDLE;
			fccm_pkg::S_IDLE:
				if (start)
					state_nxt = fccm_pkg::S_DECODE;
			fccm_pkg::S_DECODE: begin
				if (stat.cmd == fccm_pkg::CMD_ALLOC)
					state_nxt = stat.two_at_end ? fccm_pkg::S_DONE : fccm_pkg::S_SCAN;
				else if (stat.cmd == fccm_pkg::CMD_UNUSED || !stat.in_range)
					state_nxt = fccm_pkg::S_DONE;
				else begin
					case (stat.cmd)
						fccm_pkg::CMD_READ:       state_nxt = fccm_pkg::S_RDWAIT;
						fccm_pkg::CMD_APPEND,
						fccm_pkg::CMD_FREE_CHAIN: state_nxt = fccm_pkg::S_WALK;
						fccm_pkg::CMD_NEXT:
							state_nxt = stat.clus_low ? fccm_pkg::S_DONE : fccm_pkg::S_LINK;
						default:                  state_nxt = fccm_pkg::S_DONE;
					endcase
				end
			end
			fccm_pkg::S_WALK: begin
				if (stat.is_end) begin
					if (stat.cmd == fccm_pkg::CMD_APPEND && !stat.two_at_end)
						state_nxt = fccm_pkg::S_SCAN;
					else
						state_nxt = fccm_pkg::S_DONE;
				end else if (stat.steps_at_lim || stat.is_bad || stat.link_oor)
					state_nxt = fccm_pkg::S_DONE;
			end
			fccm_pkg::S_SCAN: begin
				if (stat.is_free)
					state_nxt = (stat.cmd == fccm_pkg::CMD_APPEND) ?
						fccm_pkg::S_LINKWR : fccm_pkg::S_DONE;
				else if (stat.scan_at_end)
					state_nxt = fccm_pkg::S_DONE;
			end
			fccm_pkg::S_LINKWR,
			fccm_pkg::S_LINK,
			fccm_pkg::S_RDWAIT:
				state_nxt = fccm_pkg::S_DONE;
			fccm_pkg::S_DONE:
				state_nxt = fccm_pkg::S_IDLE;
			default:
				state_nxt = fccm_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctrl            = '0;
		ctrl.rd_sel     = fccm_pkg::RD_CLUS;
		ctrl.wr_sel     = fccm_pkg::WR_NONE;
		ctrl.res_sel    = fccm_pkg::RES_SCAN;
		ctrl.status_val = fccm_pkg::STAT_OK;
		busy            = 1'b1;
		done            = 1'b0;
		case (state_q)
			fccm_pkg::S_CLEAR: begin
				ctrl.wr_sel   = fccm_pkg::WR_CLEAR;
				ctrl.clr_step = 1'b1;
			end
			fccm_pkg::S_IDLE: begin
				busy         = 1'b0;
				ctrl.capture = start;
			end
			fccm_pkg::S_DECODE: begin
				if (stat.cmd == fccm_pkg::CMD_ALLOC) begin
					if (stat.two_at_end) begin
						ctrl.status_we  = 1'b1;
						ctrl.status_val = fccm_pkg::STAT_NOFREE;
					end else begin
						ctrl.rd_en     = 1'b1;
						ctrl.rd_sel    = fccm_pkg::RD_TWO;
						ctrl.scan_init = 1'b1;
					end
				end else if (stat.cmd == fccm_pkg::CMD_UNUSED || !stat.in_range) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_RANGE;
				end else begin
					case (stat.cmd)
						fccm_pkg::CMD_LOAD:
							ctrl.wr_sel = fccm_pkg::WR_LOAD;
						fccm_pkg::CMD_READ:
							ctrl.rd_en = 1'b1;
						fccm_pkg::CMD_APPEND,
						fccm_pkg::CMD_FREE_CHAIN: begin
							ctrl.rd_en     = 1'b1;
							ctrl.walk_init = 1'b1;
						end
						fccm_pkg::CMD_NEXT: begin
							if (stat.clus_low) begin
								ctrl.status_we  = 1'b1;
								ctrl.status_val = fccm_pkg::STAT_MARK;
							end else
								ctrl.rd_en = 1'b1;
						end
						fccm_pkg::CMD_FREE_ONE:
							ctrl.wr_sel = fccm_pkg::WR_FREE_CLUS;
						default: ;
					endcase
				end
			end
			fccm_pkg::S_WALK: begin
				if (stat.is_end) begin
					if (stat.cmd == fccm_pkg::CMD_FREE_CHAIN)
						ctrl.wr_sel = fccm_pkg::WR_FREE_CUR;
					else if (stat.two_at_end) begin
						ctrl.status_we  = 1'b1;
						ctrl.status_val = fccm_pkg::STAT_NOFREE;
					end else begin
						ctrl.rd_en     = 1'b1;
						ctrl.rd_sel    = fccm_pkg::RD_TWO;
						ctrl.scan_init = 1'b1;
					end
				end else if (stat.steps_at_lim) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_LIMIT;
				end else if (stat.is_bad) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_MARK;
				end else begin
					// free chain clears the word before leaving the table or moving on
					if (stat.cmd == fccm_pkg::CMD_FREE_CHAIN)
						ctrl.wr_sel = fccm_pkg::WR_FREE_CUR;
					if (stat.link_oor) begin
						ctrl.status_we  = 1'b1;
						ctrl.status_val = fccm_pkg::STAT_RANGE;
					end else begin
						ctrl.rd_en    = 1'b1;
						ctrl.rd_sel   = fccm_pkg::RD_LINK;
						ctrl.walk_adv = 1'b1;
					end
				end
			end
			fccm_pkg::S_SCAN: begin
				if (stat.is_free) begin
					ctrl.wr_sel  = fccm_pkg::WR_END_SCAN;
					ctrl.res_we  = 1'b1;
					ctrl.res_sel = fccm_pkg::RES_SCAN;
				end else if (stat.scan_at_end) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_NOFREE;
				end else begin
					ctrl.rd_en    = 1'b1;
					ctrl.rd_sel   = fccm_pkg::RD_SCAN_NXT;
					ctrl.scan_adv = 1'b1;
				end
			end
			fccm_pkg::S_LINKWR:
				ctrl.wr_sel = fccm_pkg::WR_LINK_TAIL;
			fccm_pkg::S_LINK: begin
				if (stat.is_bad || stat.is_end) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_MARK;
				end else if (stat.link_oor) begin
					ctrl.status_we  = 1'b1;
					ctrl.status_val = fccm_pkg::STAT_RANGE;
				end else begin
					ctrl.res_we  = 1'b1;
					ctrl.res_sel = fccm_pkg::RES_LINK;
				end
			end
			fccm_pkg::S_RDWAIT:
				ctrl.rd_we = 1'b1;
			fccm_pkg::S_DONE:
				done = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[sv/fat_cluster_chain_manager_core.sv]
`default_nettype none

// FAT cluster chain manager. A command is taken when start is high and busy low; its single
// result appears for one cycle with done high and must be taken then, as there is no
// back-pressure. After reset the table is cleared one entry per cycle, so busy stays high until
// every entry is cleared and the first command can be taken. The table sits behind one read and
// one write port, which sets the pace: allocate scans for a free entry from cluster 2 onward,
// free chain follows the links of the chain, and append follows the links and then scans. busy
// falls the cycle after done. used_clusters may be written whenever no command is in flight.
module fat_cluster_chain_manager_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [9:0]  cluster,
	input  wire logic [31:0] entry_value,
	output logic             done,
	output logic [2:0]       status,
	output logic [9:0]       result_cluster,
	output logic [31:0]      read_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);

	fccm_pkg::dp_ctrl_t ctrl;
	fccm_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fccm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	fccm_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.command        (command),
		.cluster        (cluster),
		.entry_value    (entry_value),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.status         (status),
		.result_cluster (result_cluster),
		.read_value     (read_value)
	);

`ifndef NO_ASSERTIONS
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not a single pulse followed by idle");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy && !done)
		else $error("accepted command did not raise busy");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= fccm_pkg::STAT_LIMIT))
		else $error("status code out of range");
`endif

endmodule

`default_nettype wire
